@@ rtl/pmt_pkg.sv @@
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants for the PMT section parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pmt_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_END    = 2'd2
  } pmt_kind_t;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned CRC_BYTES    = 4;
  localparam logic [12:0] OFFSET_MAX   = 13'h1fff;
  localparam logic [7:0]  COUNT_MAX    = 8'hff;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PID_H = 3'd1,
    PH_PID_L = 3'd2,
    PH_LEN_H = 3'd3,
    PH_LEN_L = 3'd4,
    PH_SKIP  = 3'd5
  } entry_phase_t;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0]  stream_count;
    logic [11:0] info_len;
    logic [12:0] pid_value;
    logic [7:0]  last_section_num;
    logic [7:0]  section_num;
    logic        current_next;
    logic [4:0]  version_num;
    logic [15:0] program_num;
    logic [11:0] section_len;
    logic        syntax_bit;
    logic [7:0]  type_code;
    pmt_kind_t   kind;
  } pmt_result_t;

  typedef struct packed {
    logic        a_vld;
    logic        b_vld;
    pmt_result_t a;
    pmt_result_t b;
  } pmt_wr_t;

endpackage

`default_nettype wire

@@ rtl/pmt_parse.sv @@
// ----------------------------------------------------------------------------
// pmt_parse
// Byte-wise section state and result formation, one byte per accepted cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             first_byte,
  input  wire logic             last_byte,
  input  wire logic [11:0]      total_bytes,
  output pmt_pkg::pmt_wr_t      wr
);
  import pmt_pkg::*;

  logic [12:0]  byte_offset, byte_offset_next;
  logic [11:0]  section_total, section_total_next;
  logic [12:0]  entries_start, entries_start_next;
  entry_phase_t entry_phase, entry_phase_next;
  logic [11:0]  skip_left, skip_left_next;
  logic [63:0]  header_shadow, header_shadow_next;
  logic [23:0]  entry_shadow, entry_shadow_next;
  logic [7:0]   entry_total, entry_total_next;

  logic [12:0] p;
  logic [7:0]  hb1, hb5;
  logic [11:0] pil;
  logic [7:0]  entry_total_cur;

  always_comb begin
    // a first byte restarts from the reset state and loads the section's byte total
    if (first_byte) begin
      p                  = '0;
      section_total_next = total_bytes;
      entries_start_next = '0;
      entry_phase_next   = PH_IDLE;
      skip_left_next     = '0;
      header_shadow_next = '0;
      entry_shadow_next  = '0;
      entry_total_cur    = '0;
    end else begin
      p                  = byte_offset;
      section_total_next = section_total;
      entries_start_next = entries_start;
      entry_phase_next   = entry_phase;
      skip_left_next     = skip_left;
      header_shadow_next = header_shadow;
      entry_shadow_next  = entry_shadow;
      entry_total_cur    = entry_total;
    end
    entry_total_next = entry_total_cur;

    hb1 = header_shadow_next[15:8];
    hb5 = header_shadow_next[47:40];
    pil = {entry_shadow_next[3:0], data_byte};

    wr       = '0;
    wr.a     = '0;
    wr.b     = '0;

    if (p < 13'd8) begin
      header_shadow_next[8*p[2:0] +: 8] = data_byte;
    end else if (p < 13'd11) begin
      entry_shadow_next = {entry_shadow_next[15:0], data_byte};
    end else if (p == 13'd11) begin
      wr.a_vld              = 1'b1;
      wr.a.kind             = KIND_HEADER;
      wr.a.type_code        = header_shadow_next[7:0];
      wr.a.syntax_bit       = hb1[7];
      wr.a.section_len      = {hb1[3:0], header_shadow_next[23:16]};
      wr.a.program_num      = {header_shadow_next[31:24], header_shadow_next[39:32]};
      wr.a.version_num      = hb5[5:1];
      wr.a.current_next     = hb5[0];
      wr.a.section_num      = header_shadow_next[55:48];
      wr.a.last_section_num = header_shadow_next[63:56];
      wr.a.pid_value        = {entry_shadow_next[20:16], entry_shadow_next[15:8]};
      wr.a.info_len         = pil;
      entries_start_next    = 13'(HEADER_BYTES) + {1'b0, pil};
      entry_phase_next      = PH_IDLE;
      skip_left_next        = '0;
      entry_shadow_next     = '0;
    end else if (p >= entries_start_next) begin
      case (entry_phase_next)
        PH_IDLE: begin
          if (({1'b0, p} + 14'(CRC_BYTES)) < {2'b00, section_total_next}) begin
            entry_shadow_next = {16'h0000, data_byte};
            entry_phase_next  = PH_PID_H;
          end
        end
        PH_PID_H: begin
          entry_shadow_next = {entry_shadow_next[18:0], data_byte[4:0]};
          entry_phase_next  = PH_PID_L;
        end
        PH_PID_L: begin
          entry_shadow_next = {entry_shadow_next[15:0], data_byte};
          entry_phase_next  = PH_LEN_H;
        end
        PH_LEN_H: begin
          skip_left_next   = {data_byte[3:0], 8'h00};
          entry_phase_next = PH_LEN_L;
        end
        PH_LEN_L: begin
          skip_left_next     = {skip_left_next[11:8], data_byte};
          wr.a_vld           = 1'b1;
          wr.a.kind          = KIND_ENTRY;
          wr.a.type_code     = entry_shadow_next[20:13];
          wr.a.pid_value     = entry_shadow_next[12:0];
          wr.a.info_len      = {skip_left_next[11:8], data_byte};
          if (entry_total_cur != COUNT_MAX) begin
            entry_total_next = entry_total_cur + 8'd1;
          end
          entry_phase_next = ({skip_left_next[11:8], data_byte} != 12'd0) ? PH_SKIP : PH_IDLE;
        end
        default: begin
          if (skip_left_next != 12'd0) begin
            skip_left_next = skip_left_next - 12'd1;
          end
          if (skip_left_next == 12'd0) begin
            entry_phase_next = PH_IDLE;
          end
        end
      endcase
    end

    byte_offset_next = (p != OFFSET_MAX) ? p + 13'd1 : p;

    if (last_byte) begin
      wr.b_vld          = 1'b1;
      wr.b.kind         = KIND_END;
      wr.b.stream_count = entry_total_next;
    end
    if (!accept) begin
      wr.a_vld = 1'b0;
      wr.b_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      section_total <= '0;
      entries_start <= '0;
      entry_phase   <= PH_IDLE;
      skip_left     <= '0;
      header_shadow <= '0;
      entry_shadow  <= '0;
      entry_total   <= '0;
    end else if (accept) begin
      byte_offset   <= byte_offset_next;
      section_total <= section_total_next;
      entries_start <= entries_start_next;
      entry_phase   <= entry_phase_next;
      skip_left     <= skip_left_next;
      header_shadow <= header_shadow_next;
      entry_shadow  <= entry_shadow_next;
      entry_total   <= entry_total_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pmt_result_fifo.sv @@
// ----------------------------------------------------------------------------
// pmt_result_fifo
// Small result queue taking up to two results per cycle, one out on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_result_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pmt_pkg::pmt_wr_t     wr,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pmt_pkg::pmt_result_t      out_item
);
  import pmt_pkg::*;

  pmt_result_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   count, count_next;
  logic               pop;
  logic [1:0]         nwr;

  assign out_valid = (count != '0);
  assign out_item  = mem[rptr];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign nwr       = {1'b0, wr.a_vld} + {1'b0, wr.b_vld};

  always_comb begin
    count_next = count + {{(FIFO_AW-1){1'b0}}, nwr} - {{FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (wr.a_vld) begin
      mem[wptr] <= wr.a;
      if (wr.b_vld) begin
        mem[wptr + FIFO_AW'(1)] <= wr.b;
      end
    end else if (wr.b_vld) begin
      mem[wptr] <= wr.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + FIFO_AW'(nwr);
      if (pop) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pmt_section_parser_core.sv @@
// ----------------------------------------------------------------------------
// pmt_section_parser_core
// PMT section parser: header, stream entries and end-of-section results.
// ----------------------------------------------------------------------------
// One section byte is taken per cycle while s_axis_tready is high; its results
// (at most two) are formed in the same cycle and written into a four-entry
// result queue, which hands out one result per cycle on m_axis_tready. Input
// stalls only while the queue holds more than two results, so the byte rate
// is set by how fast the downstream side drains results.
`default_nettype none

module pmt_section_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // data_byte[7:0], total_bytes[19:8]
  input  wire logic        s_axis_tuser,   // first_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // type_code, syntax_bit, section_len,
                                           // program_num, version_num, current_next,
                                           // section_num, last_section_num,
                                           // pid_value, info_len, stream_count
  output logic [1:0]       m_axis_tuser    // kind
);
  import pmt_pkg::*;

  logic        accept;
  pmt_wr_t     wr;
  pmt_result_t res;

  assign accept = s_axis_tvalid && s_axis_tready;

  pmt_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_axis_tdata[7:0]),
    .first_byte  (s_axis_tuser),
    .last_byte   (s_axis_tlast),
    .total_bytes (s_axis_tdata[19:8]),
    .wr          (wr)
  );

  pmt_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .room      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {4'h0, res.stream_count, res.info_len, res.pid_value,
                         res.last_section_num, res.section_num, res.current_next,
                         res.version_num, res.program_num, res.section_len,
                         res.syntax_bit, res.type_code};

endmodule

`default_nettype wire

@@ test/tb_pmt_section_parser_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pmt_section_parser_core
// Self-checking bench for the PMT section parser core.
// ----------------------------------------------------------------------------
// Section bytes are queued up front: a short directed run over the corner
// cases, then mostly well-formed PMT sections with random content, plus cut
// sections, bad byte totals, raw noise, bytes running on past the end and one
// section long enough to saturate the entry count. A bit-exact model of the
// parser predicts every header, entry and end result as each byte is taken;
// the output stream is checked field by field against it. The sender runs in
// random bursts and the receiver stalls in several patterns.

module tb_pmt_section_parser_core;
  import pmt_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 10;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 60;
  localparam int MAX_REPORTS  = 10;

  // receiver stall patterns
  localparam logic [1:0] RX_OPEN   = 2'd0;
  localparam logic [1:0] RX_COIN   = 2'd1;
  localparam logic [1:0] RX_SPARSE = 2'd2;
  localparam logic [1:0] RX_TOGGLE = 2'd3;

  typedef struct {
    logic [7:0]  data;
    logic        is_first;
    logic        is_last;
    logic [11:0] total;
  } section_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  pmt_section_parser_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  section_byte_t pending_bytes[$];
  pmt_result_t   expected_results[$];

  int stim_bytes    = 0;
  int section_count = 0;
  int mismatches    = 0;
  int header_seen   = 0;
  int entry_seen    = 0;
  int end_seen      = 0;

  // parser model state
  logic [12:0] byte_ofs;
  logic [11:0] sec_total;
  logic [12:0] es_start;
  logic [2:0]  es_phase;
  logic [11:0] es_skip;
  logic [7:0]  hdr_bytes [8];
  logic [23:0] es_shadow;
  logic [7:0]  es_count;

  function automatic void clear_parser();
    byte_ofs  = '0;
    sec_total = '0;
    es_start  = '0;
    es_phase  = PH_IDLE;
    es_skip   = '0;
    es_shadow = '0;
    es_count  = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
  endfunction

  function automatic void parse_pmt_byte(input logic [7:0] b, input logic is_first,
                                         input logic is_last, input logic [11:0] total);
    pmt_result_t rec;
    int unsigned ofs;
    logic [11:0] pil;
    if (is_first) begin
      clear_parser();
      sec_total = total;
    end
    ofs = byte_ofs;
    if (ofs < 8) begin
      hdr_bytes[ofs] = b;
    end else if (ofs < HEADER_BYTES - 1) begin
      es_shadow = {es_shadow[15:0], b};
    end else if (ofs == HEADER_BYTES - 1) begin
      pil                  = {es_shadow[3:0], b};
      rec                  = '0;
      rec.kind             = KIND_HEADER;
      rec.type_code        = hdr_bytes[0];
      rec.syntax_bit       = hdr_bytes[1][7];
      rec.section_len      = {hdr_bytes[1][3:0], hdr_bytes[2]};
      rec.program_num      = {hdr_bytes[3], hdr_bytes[4]};
      rec.version_num      = hdr_bytes[5][5:1];
      rec.current_next     = hdr_bytes[5][0];
      rec.section_num      = hdr_bytes[6];
      rec.last_section_num = hdr_bytes[7];
      rec.pid_value        = es_shadow[20:8];
      rec.info_len         = pil;
      expected_results.push_back(rec);
      es_start  = 13'(HEADER_BYTES) + {1'b0, pil};
      es_phase  = PH_IDLE;
      es_skip   = '0;
      es_shadow = '0;
    end else if (ofs >= es_start) begin
      case (es_phase)
        PH_IDLE: begin
          if (ofs + CRC_BYTES < sec_total) begin
            es_shadow = {16'h0, b};
            es_phase  = PH_PID_H;
          end
        end
        PH_PID_H: begin
          es_shadow = {es_shadow[18:0], b[4:0]};
          es_phase  = PH_PID_L;
        end
        PH_PID_L: begin
          es_shadow = {es_shadow[15:0], b};
          es_phase  = PH_LEN_H;
        end
        PH_LEN_H: begin
          es_skip  = {b[3:0], 8'h00};
          es_phase = PH_LEN_L;
        end
        PH_LEN_L: begin
          es_skip       = {es_skip[11:8], b};
          rec           = '0;
          rec.kind      = KIND_ENTRY;
          rec.type_code = es_shadow[20:13];
          rec.pid_value = es_shadow[12:0];
          rec.info_len  = es_skip;
          expected_results.push_back(rec);
          if (es_count != COUNT_MAX) es_count++;
          es_phase = (es_skip != 0) ? PH_SKIP : PH_IDLE;
        end
        default: begin
          if (es_skip != 0) es_skip--;
          if (es_skip == 0) es_phase = PH_IDLE;
        end
      endcase
    end
    if (byte_ofs != OFFSET_MAX) byte_ofs++;
    if (is_last) begin
      rec              = '0;
      rec.kind         = KIND_END;
      rec.stream_count = es_count;
      expected_results.push_back(rec);
    end
  endfunction

  function automatic string result_text(input pmt_result_t r);
    return $sformatf({"kind=%0d type=%02h syn=%0d slen=%03h prog=%04h ver=%0d cn=%0d ",
                      "sec=%02h last=%02h pid=%04h ilen=%03h cnt=%0d"},
                     r.kind, r.type_code, r.syntax_bit, r.section_len, r.program_num,
                     r.version_num, r.current_next, r.section_num, r.last_section_num,
                     r.pid_value, r.info_len, r.stream_count);
  endfunction

  // ---- stimulus -----------------------------------------------------------

  task automatic queue_byte(input logic [7:0] b, input logic is_first, input logic is_last,
                            input logic [11:0] total);
    section_byte_t item;
    item.data     = b;
    item.is_first = is_first;
    item.is_last  = is_last;
    item.total    = total;
    pending_bytes.push_back(item);
    stim_bytes++;
  endtask

  // Builds a PMT section with random content; unless keep_total is set the
  // byte total may be skewed, and if truncate is set the section is cut short.
  task automatic queue_section(input int n_entries, input int max_desc, input bit truncate,
                               input bit keep_total);
    logic [7:0] sec[$];
    int         pil;
    int         es_len;
    int         slen;
    int         total;
    int         cut;
    int         skew;
    pil = $urandom_range(0, max_desc);
    for (int i = 0; i < 8; i++) sec.push_back(8'($urandom_range(0, 255)));
    sec.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(0, 31))});
    sec.push_back(8'($urandom_range(0, 255)));
    sec.push_back({4'($urandom_range(0, 15)), 4'(pil >> 8)});
    sec.push_back(8'(pil));
    for (int i = 0; i < pil; i++) sec.push_back(8'($urandom_range(0, 255)));
    for (int e = 0; e < n_entries; e++) begin
      es_len = $urandom_range(0, max_desc);
      sec.push_back(8'($urandom_range(0, 255)));
      sec.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(0, 31))});
      sec.push_back(8'($urandom_range(0, 255)));
      sec.push_back({4'($urandom_range(0, 15)), 4'(es_len >> 8)});
      sec.push_back(8'(es_len));
      for (int i = 0; i < es_len; i++) sec.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < CRC_BYTES; i++) sec.push_back(8'($urandom_range(0, 255)));
    slen   = sec.size() - 3;
    sec[1] = {sec[1][7:4], 4'(slen >> 8)};
    sec[2] = 8'(slen);
    skew   = keep_total ? 9 : $urandom_range(0, 9);
    if (skew == 0) total = $urandom_range(0, 3);
    else if (skew == 1) total = sec.size() - $urandom_range(1, 8);
    else if (skew == 2) total = sec.size() + $urandom_range(1, 8);
    else total = sec.size();
    if (total < 0) total = 0;
    cut = truncate ? $urandom_range(0, sec.size() - 1) : sec.size() - 1;
    for (int i = 0; i <= cut; i++) queue_byte(sec[i], i == 0, i == cut, 12'(total));
    section_count++;
  endtask

  task automatic queue_noise(input int count);
    for (int i = 0; i < count; i++)
      queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                 $urandom_range(0, 7) == 0, 12'($urandom_range(0, 4095)));
  endtask

  initial begin
    int pick;
    int extra;
    int n;

    // bytes before any section start, ending with a last byte
    queue_byte(8'h00, 1'b0, 1'b0, 12'h000);
    queue_byte(8'hff, 1'b0, 1'b1, 12'hfff);
    // start and end on the same byte
    queue_byte(8'hff, 1'b1, 1'b1, 12'hfff);
    // all-ones header, section ends right after it
    for (int i = 0; i < 12; i++) queue_byte(8'hff, i == 0, i == 11, 12'hfff);
    // bytes running on past the end without a new start
    queue_byte(8'h00, 1'b0, 1'b0, 12'h000);
    queue_byte(8'h00, 1'b0, 1'b1, 12'h000);
    // section ends before the header is complete
    for (int i = 0; i < 6; i++) queue_byte(8'h00, i == 0, i == 5, 12'h000);

    extra = stim_bytes;
    while (stim_bytes < extra + RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        queue_section($urandom_range(0, 6), ($urandom_range(0, 3) == 0) ? 0 : 10, 1'b0,
                      1'b0);
      end else if (pick < 8) begin
        queue_section($urandom_range(0, 4), 6, 1'b1, 1'b0);
      end else if (pick == 8) begin
        queue_noise($urandom_range(4, 30));
      end else begin
        queue_section($urandom_range(0, 3), 4, 1'b0, 1'b0);
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          queue_byte(8'($urandom_range(0, 255)), 1'b0, i == n - 1, 12'h000);
      end
    end
    // entry count saturation
    queue_section(260, 0, 1'b0, 1'b1);
    queue_section($urandom_range(1, 4), 8, 1'b0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending_bytes.size() != 0 || s_axis_tvalid);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d section bytes over %0d built sections plus directed and noise runs.",
             stim_bytes, section_count);
    $display("Checked %0d headers, %0d stream entries, %0d section ends; %0d mismatches.",
             header_seen, entry_seen, end_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---- sender: bursts with random gaps ------------------------------------

  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    section_byte_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        item = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, item.total, item.data};
        s_axis_tuser  <= item.is_first;
        s_axis_tlast  <= item.is_last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---- receiver: stall patterns -------------------------------------------

  logic [1:0] rx_mode      = RX_OPEN;
  int         rx_mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= 2'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  // ---- monitor: predict on input, check on output -------------------------

  int idle_cycles = 0;

  initial clear_parser();

  always @(posedge clk) begin
    pmt_result_t seen;
    pmt_result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        parse_pmt_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast, s_axis_tdata[19:8]);

      if (m_axis_tvalid && m_axis_tready) begin
        seen                  = '0;
        seen.kind             = pmt_kind_t'(m_axis_tuser);
        seen.type_code        = m_axis_tdata[7:0];
        seen.syntax_bit       = m_axis_tdata[8];
        seen.section_len      = m_axis_tdata[20:9];
        seen.program_num      = m_axis_tdata[36:21];
        seen.version_num      = m_axis_tdata[41:37];
        seen.current_next     = m_axis_tdata[42];
        seen.section_num      = m_axis_tdata[50:43];
        seen.last_section_num = m_axis_tdata[58:51];
        seen.pid_value        = m_axis_tdata[71:59];
        seen.info_len         = m_axis_tdata[83:72];
        seen.stream_count     = m_axis_tdata[91:84];
        case (seen.kind)
          KIND_HEADER: header_seen++;
          KIND_ENTRY:  entry_seen++;
          default:     end_seen++;
        endcase
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result: %s", $realtime, result_text(seen));
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== seen.kind || want.type_code !== seen.type_code ||
              want.syntax_bit !== seen.syntax_bit || want.section_len !== seen.section_len ||
              want.program_num !== seen.program_num ||
              want.version_num !== seen.version_num ||
              want.current_next !== seen.current_next ||
              want.section_num !== seen.section_num ||
              want.last_section_num !== seen.last_section_num ||
              want.pid_value !== seen.pid_value || want.info_len !== seen.info_len ||
              want.stream_count !== seen.stream_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", result_text(want));
              $display("  actual   %s", result_text(seen));
            end
          end
        end
      end

      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, expected_results.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
